@@ rtl/core/idafsm_pkg.sv @@
`timescale 1ns / 1ps

package idafsm_pkg;

  // Receiver codes shared by all three infrared receivers.
  localparam logic [1:0] IR_NONE   = 2'd0;
  localparam logic [1:0] IR_LEFT   = 2'd1;
  localparam logic [1:0] IR_CENTER = 2'd2;
  localparam logic [1:0] IR_RIGHT  = 2'd3;

  // Input command codes.
  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_RESTART_TURN  = 2'd0;
  localparam logic [1:0] CFG_SPIN_LIMIT    = 2'd1;
  localparam logic [1:0] CFG_REVERSE_TICKS = 2'd2;

  localparam int CFG_DATA_W = 16;

  // Motion constants.
  localparam logic signed [11:0] TURN_SLOW  = 12'sd200;
  localparam logic signed [7:0]  BACK_SPEED = -8'sd100;

  // Register reset values.
  localparam logic signed [11:0] RESTART_TURN_RST  = 12'sd200;
  localparam logic [15:0]        SPIN_LIMIT_RST    = 16'd27166;
  localparam logic [7:0]         REVERSE_TICKS_RST = 8'd40;

  typedef enum logic [2:0] {
    PH_SCAN       = 3'd0,
    PH_FIND       = 3'd1,
    PH_GET        = 3'd2,
    PH_SCAN_ALIGN = 3'd3,
    PH_ALIGNED    = 3'd4,
    PH_DOCKING    = 3'd5,
    PH_DOCKED     = 3'd6
  } phase_t;

  typedef struct packed {
    logic               command;
    logic [1:0]         ir_left;
    logic [1:0]         ir_mid;
    logic [1:0]         ir_right;
    logic signed [15:0] yaw_step;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]         phase;
    logic signed [7:0]  linear_speed;
    logic signed [11:0] turn_speed;
  } out_beat_t;

endpackage

@@ rtl/core/infrared_dock_approach_fsm_core.sv @@
`timescale 1ns / 1ps
// An accepted beat is held in the input register, then in the result register.
// Throughput: one beat per cycle unless stalled; the input register feeds the
// docking FSM and the result register, and the state updates as a beat moves on.
// Reset (rst, synchronous, active high): phase returns to scan, rotation sum,
// side tally and reverse count clear, registers take their default values.
module infrared_dock_approach_fsm_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  idafsm_pkg::in_beat_t                 in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output idafsm_pkg::out_beat_t                out_data,
  input  logic                                 cfg_we,
  input  logic [1:0]                           cfg_index,
  input  logic [idafsm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import idafsm_pkg::*;

  // Configuration registers.
  logic signed [11:0] restart_turn_rate;
  logic [15:0]        spin_limit;
  logic [7:0]         reverse_ticks;

  // Input stage and its payload.
  logic     stage_valid;
  in_beat_t stage;
  logic     advance;

  // Controller state.
  phase_t             phase;
  phase_t             phase_next;
  logic signed [23:0] rotation_sum;
  logic signed [23:0] rotation_sum_next;
  logic signed [15:0] side_tally;
  logic signed [15:0] side_tally_next;
  logic [7:0]         reverse_count;
  logic [7:0]         reverse_count_next;

  // Shared arithmetic on the staged beat.
  logic signed [24:0] rot_wide;
  logic signed [23:0] rot_added;
  logic [24:0]        rot_mag;
  logic               full_turn;
  logic signed [15:0] tally_inc;
  logic signed [15:0] tally_dec;
  logic [7:0]         reverse_inc;

  logic signed [7:0]  lin_cmd;
  logic signed [11:0] turn_cmd;

  // Configuration writes are registered. Indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      restart_turn_rate <= RESTART_TURN_RST;
      spin_limit        <= SPIN_LIMIT_RST;
      reverse_ticks     <= REVERSE_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RESTART_TURN:  restart_turn_rate <= $signed(cfg_data[11:0]);
        CFG_SPIN_LIMIT:    spin_limit        <= cfg_data[15:0];
        CFG_REVERSE_TICKS: reverse_ticks     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // The staged beat moves into the result register whenever that register is
  // empty or being drained this cycle. The input side can therefore take a new
  // beat every cycle while the downstream keeps up, and holds one waiting beat
  // in the stage when it stalls.
  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage <= in_data;
    end
  end

  // Saturating yaw accumulation: widen by one bit, clamp on overflow.
  assign rot_wide = {rotation_sum[23], rotation_sum} + {{9{stage.yaw_step[15]}}, stage.yaw_step};

  always_comb begin
    if (rot_wide[24] != rot_wide[23]) begin
      rot_added = rot_wide[24] ? 24'sh800000 : 24'sh7FFFFF;
    end else begin
      rot_added = rot_wide[23:0];
    end
  end

  // A full turn is a magnitude strictly above the limit, tested after the add.
  assign rot_mag   = rot_added[23] ? (25'd0 - {rot_added[23], rot_added})
                                   : {1'b0, rot_added};
  assign full_turn = rot_mag > {9'd0, spin_limit};

  assign tally_inc   = (side_tally == 16'sh7FFF) ? side_tally : side_tally + 16'sd1;
  assign tally_dec   = (side_tally == 16'sh8000) ? side_tally : side_tally - 16'sd1;
  assign reverse_inc = (reverse_count == 8'hFF) ? reverse_count : reverse_count + 8'd1;

  // Next phase and state update.
  always_comb begin
    phase_next         = phase;
    rotation_sum_next  = rotation_sum;
    side_tally_next    = side_tally;
    reverse_count_next = reverse_count;
    if (stage.command == CMD_RESTART) begin
      phase_next         = PH_SCAN;
      rotation_sum_next  = '0;
      side_tally_next    = '0;
      reverse_count_next = '0;
    end else begin
      unique case (phase)
        PH_FIND: begin
          if (side_tally > 0) begin
            if (stage.ir_right == IR_RIGHT) phase_next = PH_GET;
          end else if (side_tally < 0) begin
            if (stage.ir_left == IR_LEFT) phase_next = PH_GET;
          end else if (stage.ir_mid == IR_CENTER) begin
            phase_next        = PH_ALIGNED;
            side_tally_next   = '0;
            rotation_sum_next = '0;
          end
        end
        PH_GET: begin
          if (side_tally > 0) begin
            if (stage.ir_right == IR_CENTER) begin
              phase_next        = PH_SCAN_ALIGN;
              side_tally_next   = '0;
              rotation_sum_next = '0;
            end
          end else if (side_tally < 0) begin
            if (stage.ir_left == IR_CENTER) begin
              phase_next        = PH_SCAN_ALIGN;
              side_tally_next   = '0;
              rotation_sum_next = '0;
            end
          end else begin
            phase_next = PH_SCAN;
          end
        end
        PH_SCAN_ALIGN: begin
          rotation_sum_next = rot_added;
          if (stage.ir_mid == IR_CENTER) begin
            phase_next        = PH_ALIGNED;
            side_tally_next   = '0;
            rotation_sum_next = '0;
          end else if (full_turn) begin
            phase_next        = PH_SCAN;
            rotation_sum_next = '0;
          end
        end
        PH_ALIGNED: begin
          if (stage.ir_mid == IR_CENTER) begin
            phase_next = PH_DOCKING;
          end else if (stage.ir_mid == IR_LEFT || stage.ir_mid == IR_RIGHT) begin
            phase_next = PH_SCAN;
          end
        end
        PH_DOCKING: begin
          if (reverse_count > reverse_ticks) begin
            phase_next         = PH_DOCKED;
            reverse_count_next = '0;
          end else if (stage.ir_mid == IR_CENTER) begin
            reverse_count_next = reverse_inc;
          end
        end
        PH_DOCKED: ;
        default: begin
          // Scan, and the unreachable eighth code, which behaves the same.
          phase_next        = PH_SCAN;
          rotation_sum_next = rot_added;
          if (stage.ir_mid == IR_CENTER) begin
            phase_next        = PH_ALIGNED;
            side_tally_next   = '0;
            rotation_sum_next = '0;
          end else if (stage.ir_mid == IR_LEFT || stage.ir_right == IR_LEFT) begin
            side_tally_next = tally_dec;
          end else if (stage.ir_mid == IR_RIGHT || stage.ir_left == IR_RIGHT) begin
            side_tally_next = tally_inc;
          end else if (full_turn) begin
            phase_next        = PH_FIND;
            rotation_sum_next = '0;
          end
        end
      endcase
    end
  end

  // Speed commands for the staged beat.
  always_comb begin
    lin_cmd  = '0;
    turn_cmd = '0;
    if (stage.command == CMD_RESTART) begin
      turn_cmd = restart_turn_rate;
    end else begin
      unique case (phase)
        PH_FIND: begin
          if (side_tally > 0) begin
            if (stage.ir_right != IR_RIGHT) turn_cmd = TURN_SLOW;
          end else if (side_tally < 0) begin
            if (stage.ir_left != IR_LEFT) turn_cmd = -TURN_SLOW;
          end else if (stage.ir_mid != IR_CENTER) begin
            turn_cmd = TURN_SLOW;
          end
        end
        PH_GET: begin
          if (side_tally > 0) begin
            if (stage.ir_right == IR_CENTER) turn_cmd = TURN_SLOW;
            else                             lin_cmd  = BACK_SPEED;
          end else if (side_tally < 0) begin
            if (stage.ir_left == IR_CENTER) turn_cmd = -TURN_SLOW;
            else                            lin_cmd  = BACK_SPEED;
          end
        end
        PH_SCAN_ALIGN: begin
          if (stage.ir_mid != IR_CENTER && !full_turn) turn_cmd = -TURN_SLOW;
        end
        PH_ALIGNED: ;
        PH_DOCKING: begin
          if (!(reverse_count > reverse_ticks) && stage.ir_mid == IR_CENTER) begin
            lin_cmd = BACK_SPEED;
          end
        end
        PH_DOCKED: ;
        default: begin
          // In scan every outcome but reaching the center beam keeps turning.
          if (stage.ir_mid != IR_CENTER) turn_cmd = TURN_SLOW;
        end
      endcase
    end
  end

  // Controller state commits only when its beat moves to the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SCAN;
      rotation_sum  <= '0;
      side_tally    <= '0;
      reverse_count <= '0;
    end else if (advance) begin
      phase         <= phase_next;
      rotation_sum  <= rotation_sum_next;
      side_tally    <= side_tally_next;
      reverse_count <= reverse_count_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.phase        <= phase_next;
      out_data.linear_speed <= lin_cmd;
      out_data.turn_speed   <= turn_cmd;
    end
  end

endmodule

@@ rtl/core/idafsm_checker.sv @@
`timescale 1ns / 1ps
module idafsm_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  idafsm_pkg::out_beat_t out_data
);
  import idafsm_pkg::*;

  // A result beat held back by the sink stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Nothing is delivered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result beat present right after reset");

  // In the docked phase the robot stands still.
  a_docked_still: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.phase == PH_DOCKED |->
      out_data.linear_speed == 8'sd0 && out_data.turn_speed == 12'sd0)
    else $error("motion commanded while docked");

  // The only linear motion is the fixed reverse speed.
  a_lin_values: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.linear_speed == 8'sd0 || out_data.linear_speed == BACK_SPEED)
    else $error("unexpected linear speed");

  // Any reverse motion happens in the get or docking phase only.
  a_reverse_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.linear_speed != 8'sd0 |->
      out_data.phase == PH_GET || out_data.phase == PH_DOCKING)
    else $error("reverse motion in wrong phase");

endmodule

bind infrared_dock_approach_fsm_core idafsm_checker u_idafsm_checker (.*);
